[hw/rtl/neighbor_average_smoother_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef NEIGHBOR_AVERAGE_SMOOTHER_UNIT_DEFINES_SVH
`define NEIGHBOR_AVERAGE_SMOOTHER_UNIT_DEFINES_SVH

// Overlapping implication, disabled while reset is low
`define NAS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nas_checker: property failed");

// Next-cycle implication, disabled while reset is low
`define NAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nas_checker: property failed");

`endif

[hw/rtl/nas_pkg.sv]
`default_nettype none

package nas_pkg;

    // Frame geometry
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int SAMPLE_BITS   = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int OUT_ROW_BITS  = 12;
    localparam int IN_ROW_BITS   = 13;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // Arithmetic widths: eight-term sum, biased dividend, reciprocal, product
    localparam int SUM_BITS   = SAMPLE_BITS + 3;
    localparam int DVD_BITS   = SAMPLE_BITS + 4;
    localparam int RECIP_BITS = 21;
    localparam int PROD_BITS  = DVD_BITS + RECIP_BITS;

    // Bias d * 2^16 makes the dividend non-negative; reciprocals ceil(2^k / d)
    localparam logic [DVD_BITS-1:0] BIAS_3 = DVD_BITS'(3 * (1 << SAMPLE_BITS));
    localparam logic [DVD_BITS-1:0] BIAS_5 = DVD_BITS'(5 * (1 << SAMPLE_BITS));
    localparam logic [DVD_BITS-1:0] BIAS_8 = DVD_BITS'(8 * (1 << SAMPLE_BITS));
    localparam int SHIFT_3 = 22;
    localparam int SHIFT_5 = 23;
    localparam int SHIFT_8 = 23;
    localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((1 << SHIFT_3) + 2) / 3);
    localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((1 << SHIFT_5) + 4) / 5);
    localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'((1 << SHIFT_8) / 8);

    // Result queue
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // Number of in-frame neighbours
    typedef enum logic [1:0] {
        CNT_3,
        CNT_5,
        CNT_8
    } t_nbr_cnt;

    // Border flags travelling with an item into the window stage
    typedef struct packed {
        logic     ex_top;
        logic     ex_bot;
        logic     ex_left;
        logic     ex_right;
        t_nbr_cnt cnt;
        logic     last;
    } t_win_ctrl;

    // What the divider needs besides the sum
    typedef struct packed {
        t_nbr_cnt cnt;
        logic     last;
    } t_div_ctrl;

    // One line memory word: both earlier rows of a column
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] upper;
        logic [SAMPLE_BITS-1:0] middle;
    } t_line_word;

    // One queued result
    typedef struct packed {
        logic                   last;
        logic [SAMPLE_BITS-1:0] value;
    } t_out_entry;

endpackage

`default_nettype wire

[hw/rtl/neighbor_average_smoother_unit.sv]
// Neighbor average smoother: 3x3 box average of a height map with the center left out.
// Input channel (i_s_axis_*): one signed Q8.8 sample per request in raster order, x fastest.
//   tuser set marks a flush request; flushes count only after a frame's last sample,
//   and frame_width+1 of them drain the remaining results. Earlier flushes are dropped.
// Output channel (o_m_axis_*): one Q8.8 average per position; tlast marks the frame's
//   final position and restarts the frame.
// Config: i_cfg_we with i_cfg_index 0 (frame_width) or 1 (frame_height); values are
//   clamped to 2..1024 and 2..4096. A write to either restarts the frame; write only when idle.
// Throughput: one request per cycle while input ready is high. Results lag the input by
//   frame_width+1 positions; after that, each result passes the line memory read, window
//   shift, sum, multiply and quotient registers before it enters the output queue.
// A single line memory holds both earlier rows per column, read and written back in
//   consecutive cycles; successive requests that write it always hit different columns.
// Reset clears counters, window and queue; the line memory needs no clearing pass.
// When the receiver stalls, results gather in an eight-entry queue; input ready drops
//   once eight results are queued or in flight.
`default_nettype none

module neighbor_average_smoother_unit import nas_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample_value
    input  logic [SAMPLE_BITS-1:0]   i_s_axis_tdata,
    // flush
    input  logic                     i_s_axis_tuser,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // smoothed_value
    output logic [SAMPLE_BITS-1:0]   o_m_axis_tdata,
    output logic                     o_m_axis_tlast,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration
    logic [WIDTH_BITS-1:0]   r_width;
    logic [HEIGHT_BITS-1:0]  r_height;
    logic [WIDTH_BITS-1:0]   w_width_raw;
    logic [HEIGHT_BITS-1:0]  w_height_raw;
    logic                    w_restart_cfg;

    // position counters
    logic [COL_BITS-1:0]     r_in_col,  n_in_col;
    logic [IN_ROW_BITS-1:0]  r_in_row,  n_in_row;
    logic [COL_BITS-1:0]     r_out_col, n_out_col;
    logic [OUT_ROW_BITS-1:0] r_out_row, n_out_row;

    // request stage
    logic                    w_accept;
    logic                    w_draining;
    logic                    w_proc;
    logic                    w_emit;
    logic [WIDTH_BITS-1:0]   w_col_inc;
    logic [WIDTH_BITS-1:0]   w_ocol_inc;
    logic                    w_top, w_bot, w_left, w_right;
    t_win_ctrl               w_ctrl;

    // memory stage
    logic                    r_s1_valid;
    logic                    r_s1_emit;
    logic                    r_s1_drain;
    logic [COL_BITS-1:0]     r_s1_addr;
    logic [SAMPLE_BITS-1:0]  r_s1_sample;
    t_win_ctrl               r_s1_ctrl;
    t_line_word              w_rd_data;
    t_line_word              w_wr_word;

    logic                    w_sum_valid;
    logic signed [SUM_BITS-1:0] w_sum;
    t_div_ctrl               w_sum_ctrl;
    logic                    w_div_valid;
    logic [SAMPLE_BITS-1:0]  w_div_value;
    logic                    w_div_last;
    logic                    w_room;

    assign w_width_raw  = i_cfg_data[WIDTH_BITS-1:0];
    assign w_height_raw = i_cfg_data[HEIGHT_BITS-1:0];
    assign w_restart_cfg = i_cfg_we &&
                           (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    // register writes, clamped to the legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_BITS'(1024);
            r_height <= HEIGHT_BITS'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (w_width_raw < WIDTH_BITS'(2)) begin
                        r_width <= WIDTH_BITS'(2);
                    end else if (w_width_raw > WIDTH_BITS'(MAX_WIDTH)) begin
                        r_width <= WIDTH_BITS'(MAX_WIDTH);
                    end else begin
                        r_width <= w_width_raw;
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (w_height_raw < HEIGHT_BITS'(2)) begin
                        r_height <= HEIGHT_BITS'(2);
                    end else if (w_height_raw > HEIGHT_BITS'(MAX_HEIGHT)) begin
                        r_height <= HEIGHT_BITS'(MAX_HEIGHT);
                    end else begin
                        r_height <= w_height_raw;
                    end
                end
                default: begin
                    r_width  <= r_width;
                    r_height <= r_height;
                end
            endcase
        end
    end

    // request decode
    assign o_s_axis_tready = w_room;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_draining = r_in_row >= IN_ROW_BITS'(r_height);
    assign w_proc     = w_accept && (w_draining || !i_s_axis_tuser);
    assign w_emit     = (r_in_row > IN_ROW_BITS'(1)) ||
                        (r_in_row == IN_ROW_BITS'(1) && r_in_col != '0);
    assign w_col_inc  = WIDTH_BITS'(r_in_col) + WIDTH_BITS'(1);
    assign w_ocol_inc = WIDTH_BITS'(r_out_col) + WIDTH_BITS'(1);

    // border of the output position
    assign w_top   = r_out_row == '0;
    assign w_bot   = HEIGHT_BITS'(r_out_row) >= HEIGHT_BITS'(r_height - HEIGHT_BITS'(1));
    assign w_left  = r_out_col == '0;
    assign w_right = WIDTH_BITS'(r_out_col) >= WIDTH_BITS'(r_width - WIDTH_BITS'(1));

    always_comb begin
        w_ctrl.ex_top   = w_top;
        w_ctrl.ex_bot   = w_bot;
        w_ctrl.ex_left  = w_left;
        w_ctrl.ex_right = w_right;
        w_ctrl.last     = w_right && w_bot;
        unique case ({w_top || w_bot, w_left || w_right})
            2'b11:         w_ctrl.cnt = CNT_3;
            2'b10, 2'b01:  w_ctrl.cnt = CNT_5;
            2'b00:         w_ctrl.cnt = CNT_8;
            default:       w_ctrl.cnt = CNT_8;
        endcase
    end

    // counter update
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_restart_cfg) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (w_proc) begin
            if (w_col_inc >= r_width) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_BITS'(1);
            end else begin
                n_in_col = w_col_inc[COL_BITS-1:0];
            end
            if (w_emit) begin
                if (w_ctrl.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (w_ocol_inc >= r_width) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_BITS'(1);
                end else begin
                    n_out_col = w_ocol_inc[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // memory stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_s1_emit   <= w_emit;
            r_s1_drain  <= w_draining;
            r_s1_addr   <= r_in_col;
            r_s1_sample <= w_draining ? '0 : i_s_axis_tdata;
            r_s1_ctrl   <= w_ctrl;
        end
    end

    // write-back word: middle row moves up, new sample becomes the middle row
    assign w_wr_word = '{upper: w_rd_data.middle, middle: r_s1_sample};

    // line memory: read at request, write back in the next cycle (rows move up)
    nas_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_proc),
        .i_rd_addr (r_in_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_valid && !r_s1_drain),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_word)
    );

    nas_window_sum u_window_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_emit   (r_s1_emit),
        .i_ctrl   (r_s1_ctrl),
        .i_upper  ($signed(w_rd_data.upper)),
        .i_middle ($signed(w_rd_data.middle)),
        .i_lower  ($signed(r_s1_sample)),
        .o_valid  (w_sum_valid),
        .o_sum    (w_sum),
        .o_ctrl   (w_sum_ctrl)
    );

    nas_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .i_ctrl  (w_sum_ctrl),
        .o_valid (w_div_valid),
        .o_value (w_div_value),
        .o_last  (w_div_last)
    );

    nas_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_reserve    (w_proc && w_emit),
        .o_room       (w_room),
        .i_push       (w_div_valid),
        .i_push_value (w_div_value),
        .i_push_last  (w_div_last),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_value      (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/nas_line_mem.sv]
`default_nettype none

module nas_line_mem import nas_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [COL_BITS-1:0] i_rd_addr,
    output t_line_word          o_rd_data,
    input  logic                i_wr_en,
    input  logic [COL_BITS-1:0] i_wr_addr,
    input  t_line_word          i_wr_data
);

    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/nas_window_sum.sv]
`default_nettype none

module nas_window_sum import nas_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic                          i_emit,
    input  t_win_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_upper,
    input  logic signed [SAMPLE_BITS-1:0] i_middle,
    input  logic signed [SAMPLE_BITS-1:0] i_lower,
    output logic                          o_valid,
    output logic signed [SUM_BITS-1:0]    o_sum,
    output t_div_ctrl                     o_ctrl
);

    // r_win[row][col], column 2 is the newest
    logic signed [SAMPLE_BITS-1:0] r_win [3][3];
    logic                          r_win_valid;
    t_win_ctrl                     r_win_ctrl;
    logic                          r_sum_valid;
    logic signed [SUM_BITS-1:0]    r_sum;
    t_div_ctrl                     r_sum_ctrl;

    logic [2:0]                    w_row_on;
    logic [2:0]                    w_col_on;
    logic signed [SUM_BITS-1:0]    n_sum;

    // window shift, one column per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
        end else begin
            r_win_valid <= i_shift && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win_ctrl <= i_ctrl;
        end
    end

    // border masks
    assign w_row_on = {!r_win_ctrl.ex_bot, 1'b1, !r_win_ctrl.ex_top};
    assign w_col_on = {!r_win_ctrl.ex_right, 1'b1, !r_win_ctrl.ex_left};

    // masked sum of the eight neighbours
    always_comb begin
        n_sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (w_row_on[r] && w_col_on[c] && !(r == 1 && c == 1)) begin
                    n_sum = n_sum + SUM_BITS'(r_win[r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else begin
            r_sum_valid <= r_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_win_valid) begin
            r_sum           <= n_sum;
            r_sum_ctrl.cnt  <= r_win_ctrl.cnt;
            r_sum_ctrl.last <= r_win_ctrl.last;
        end
    end

    assign o_valid = r_sum_valid;
    assign o_sum   = r_sum;
    assign o_ctrl  = r_sum_ctrl;

endmodule

`default_nettype wire

[hw/rtl/nas_divider.sv]
`default_nettype none

module nas_divider import nas_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SUM_BITS-1:0] i_sum,
    input  t_div_ctrl                  i_ctrl,
    output logic                       o_valid,
    output logic [SAMPLE_BITS-1:0]     o_value,
    output logic                       o_last
);

    logic                         r_a_valid;
    t_div_ctrl                    r_a_ctrl;
    logic [PROD_BITS-1:0]         r_prod;
    logic                         r_b_valid;
    logic [SAMPLE_BITS-1:0]       r_value;
    logic                         r_last;

    logic [DVD_BITS-1:0]          w_bias;
    logic [RECIP_BITS-1:0]        w_recip;
    logic signed [DVD_BITS:0]     w_dvd_ext;
    logic [DVD_BITS-1:0]          w_dvd;
    logic [SAMPLE_BITS-1:0]       w_quot;

    // constants for the divisor
    always_comb begin
        unique case (i_ctrl.cnt)
            CNT_3: begin
                w_bias  = BIAS_3;
                w_recip = RECIP_3;
            end
            CNT_5: begin
                w_bias  = BIAS_5;
                w_recip = RECIP_5;
            end
            CNT_8: begin
                w_bias  = BIAS_8;
                w_recip = RECIP_8;
            end
            default: begin
                w_bias  = BIAS_8;
                w_recip = RECIP_8;
            end
        endcase
    end

    // biased dividend is non-negative, so floor division becomes a plain quotient
    assign w_dvd_ext = (DVD_BITS + 1)'(i_sum) + $signed({1'b0, w_bias});
    assign w_dvd     = w_dvd_ext[DVD_BITS-1:0];

    // stage A: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_a_ctrl <= i_ctrl;
            r_prod   <= PROD_BITS'(w_dvd) * PROD_BITS'(w_recip);
        end
    end

    // stage B: take the quotient; removing the 2^16 bias leaves the low bits unchanged
    always_comb begin
        unique case (r_a_ctrl.cnt)
            CNT_3:   w_quot = r_prod[SHIFT_3 +: SAMPLE_BITS];
            CNT_5:   w_quot = r_prod[SHIFT_5 +: SAMPLE_BITS];
            CNT_8:   w_quot = r_prod[SHIFT_8 +: SAMPLE_BITS];
            default: w_quot = r_prod[SHIFT_8 +: SAMPLE_BITS];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_value <= w_quot;
            r_last  <= r_a_ctrl.last;
        end
    end

    assign o_valid = r_b_valid;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[hw/rtl/nas_out_fifo.sv]
`default_nettype none

module nas_out_fifo import nas_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_reserve,
    output logic                   o_room,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS-1:0] i_push_value,
    input  logic                   i_push_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic                   o_last
);

    t_out_entry               r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] r_credit;
    logic [FIFO_CNT_BITS-1:0] n_count;
    logic [FIFO_CNT_BITS-1:0] n_credit;
    logic                     w_pop;

    assign w_pop = (r_count != '0) && i_ready;

    // credits cover results in flight plus queued ones
    always_comb begin
        n_count  = r_count + FIFO_CNT_BITS'(i_push) - FIFO_CNT_BITS'(w_pop);
        n_credit = r_credit + FIFO_CNT_BITS'(i_reserve) - FIFO_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            r_count  <= n_count;
            r_credit <= n_credit;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= '{last: i_push_last, value: i_push_value};
        end
    end

    assign o_room  = r_credit < FIFO_CNT_BITS'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_value = r_buf[r_rd_ptr].value;
    assign o_last  = r_buf[r_rd_ptr].last;

endmodule

`default_nettype wire

[hw/rtl/nas_checker.sv]
`default_nettype none
`include "neighbor_average_smoother_unit_defines.svh"

module nas_checker import nas_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_data,
    input logic                   i_out_last
);

    // queue empty and input open right after reset
    `NAS_ASSERT_IMPL(a_out_idle_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)
    `NAS_ASSERT_IMPL(a_ready_after_reset, i_clk, i_rst_n, $past(!i_rst_n), i_in_ready)

    // backpressure on the input only comes with results waiting
    `NAS_ASSERT_IMPL(a_stall_has_results, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // stalled result stays put
    `NAS_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `NAS_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data) && $stable(i_out_last))

endmodule

bind neighbor_average_smoother_unit nas_checker u_nas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_s_axis_tready),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata),
    .i_out_last  (o_m_axis_tlast)
);

`default_nettype wire

[sim/neighbor_average_smoother_unit_tb.sv]
import nas_pkg::*;

// One expected output: the floored neighbor average and the frame-end flag
typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
} t_predicted_average;

// Tracks frame position, line memories and the 3x3 window, and holds the
// averages still owed by the block in arrival order.
class neighbor_average_tracker;
    bit [WIDTH_BITS-1:0]           width_reg;
    bit [HEIGHT_BITS-1:0]          height_reg;
    bit signed [SAMPLE_BITS-1:0]   upper_line [MAX_WIDTH];
    bit signed [SAMPLE_BITS-1:0]   middle_line [MAX_WIDTH];
    bit signed [SAMPLE_BITS-1:0]   window [3][3];
    bit [COL_BITS-1:0]             in_col;
    bit [IN_ROW_BITS-1:0]          in_row;
    bit [COL_BITS-1:0]             out_col;
    bit [OUT_ROW_BITS-1:0]         out_row;
    t_predicted_average            pending_averages [$];
    int                            errors;

    function new();
        width_reg  = WIDTH_BITS'(MAX_WIDTH);
        height_reg = HEIGHT_BITS'(1024);
        errors     = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        in_col  = '0;
        in_row  = '0;
        out_col = '0;
        out_row = '0;
    endfunction

    // Register values outside the legal range are clamped
    function int eff_width();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function int eff_height();
        if (height_reg < 2) return 2;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // Any write to a real register restarts the frame; other indexes do nothing
    function void write_register(logic [CFG_IDX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] data);
        if (index == CFG_FRAME_WIDTH) begin
            width_reg = data[WIDTH_BITS-1:0];
            restart_frame();
        end else if (index == CFG_FRAME_HEIGHT) begin
            height_reg = data[HEIGHT_BITS-1:0];
            restart_frame();
        end
    endfunction

    // Accepted input request: advance the window and queue any average it completes
    function void accept_sample(logic [SAMPLE_BITS-1:0] value, logic flush);
        int w;
        int h;
        int ix;
        int iy;
        int ox;
        int oy;
        int r;
        int c;
        int r0;
        int r1;
        int c0;
        int c1;
        int cnt;
        int sum;
        int q;
        bit draining;
        bit signed [SAMPLE_BITS-1:0] sample;
        bit signed [SAMPLE_BITS-1:0] top;
        bit signed [SAMPLE_BITS-1:0] mid;
        t_predicted_average item;

        w = eff_width();
        h = eff_height();
        draining = (in_row >= h);
        // flush before the frame's last sample is dropped
        if (!draining && flush) return;

        sample = draining ? '0 : value;
        ix = int'(in_col);
        iy = int'(in_row);

        top = upper_line[ix];
        mid = middle_line[ix];
        if (!draining) begin
            upper_line[ix]  = mid;
            middle_line[ix] = sample;
        end
        for (r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = sample;

        if (ix == w - 1) begin
            in_col = '0;
            in_row = IN_ROW_BITS'(iy + 1);
        end else begin
            in_col = COL_BITS'(ix + 1);
        end

        // nothing comes out until the window center reaches row 0, column 0
        if (!(iy > 1 || (iy == 1 && ix >= 1))) return;

        ox = int'(out_col);
        oy = int'(out_row);
        r0 = (oy == 0) ? 1 : 0;
        r1 = (oy >= h - 1) ? 1 : 2;
        c0 = (ox == 0) ? 1 : 0;
        c1 = (ox >= w - 1) ? 1 : 2;

        sum = 0;
        for (r = r0; r <= r1; r++)
            for (c = c0; c <= c1; c++)
                if (!(r == 1 && c == 1))
                    sum += window[r][c];
        cnt = (r1 - r0 + 1) * (c1 - c0 + 1) - 1;

        // floor toward minus infinity
        q = sum / cnt;
        if (sum % cnt != 0 && sum < 0) q = q - 1;

        item.value = q[SAMPLE_BITS-1:0];
        item.last  = (ox >= w - 1) && (oy >= h - 1);
        pending_averages.push_back(item);

        if (item.last) begin
            restart_frame();
        end else if (ox == w - 1) begin
            out_col = '0;
            out_row = OUT_ROW_BITS'(oy + 1);
        end else begin
            out_col = COL_BITS'(ox + 1);
        end
    endfunction

    // Compare one output request with the oldest expected average
    function void check_average(logic [SAMPLE_BITS-1:0] value, logic last);
        t_predicted_average item;
        if (pending_averages.size() == 0) begin
            $error("unexpected result: smoothed_value %0d last_of_frame %0b",
                   $signed(value), last);
            errors++;
            return;
        end
        item = pending_averages.pop_front();
        if (item.value !== value) begin
            $error("smoothed_value: expected %0d, actual %0d",
                   $signed(item.value), $signed(value));
            errors++;
        end
        if (item.last !== last) begin
            $error("last_of_frame: expected %0b, actual %0b", item.last, last);
            errors++;
        end
    endfunction
endclass

module neighbor_average_smoother_unit_tb;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    localparam logic [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] MOST_POSITIVE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // Pipeline plus output queue drain time, with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;

    logic                     i_clk;
    logic                     i_rst_n;
    // [15:0] sample_value
    logic [SAMPLE_BITS-1:0]   i_s_axis_tdata;
    // [0] flush
    logic                     i_s_axis_tuser;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    // [15:0] smoothed_value
    logic [SAMPLE_BITS-1:0]   o_m_axis_tdata;
    logic                     o_m_axis_tlast;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    neighbor_average_tracker tracker;
    int send_idle_pct;
    int recv_idle_pct;
    int counted_items;

    neighbor_average_smoother_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver stalls at random
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Output requests are checked as they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_average(o_m_axis_tdata, o_m_axis_tlast);
    end

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 11))
            0:       return MOST_NEGATIVE;
            1:       return MOST_POSITIVE;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Drive one input request, idling first at random; returns at a falling edge
    task automatic send_request(input logic [SAMPLE_BITS-1:0] value, input logic flush);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= flush;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.accept_sample(value, flush);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected average is out
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_averages.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.write_register(index, data);
        @(negedge i_clk);
    endtask

    // Samples of a frame with stray flushes, then drain requests (some as samples)
    task automatic send_frame(input int samples, input int drains, input bit noisy);
        int k;
        for (k = 0; k < samples; k++) begin
            if (noisy && $urandom_range(0, 15) == 0) send_request(random_sample(), 1'b1);
            send_request(random_sample(), 1'b0);
        end
        for (k = 0; k < drains; k++)
            send_request(random_sample(), noisy ? 1'($urandom_range(0, 1)) : 1'b1);
        counted_items += samples + drains;
    endtask

    // Small random frames; some back to back, some cut short by a register write
    task automatic run_random_frames(input int item_goal);
        int start;
        int w_val;
        int h_val;
        int w;
        int h;
        int sel;
        bit must_write;
        start = counted_items;
        must_write = 1'b1;
        while (counted_items - start < item_goal) begin
            if (must_write || $urandom_range(0, 2) != 0) begin
                wait_for_results();
                case ($urandom_range(0, 9))
                    0:       w_val = $urandom_range(0, 1);
                    1, 2:    w_val = $urandom_range(9, 40);
                    default: w_val = $urandom_range(2, 8);
                endcase
                h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 6);
                sel = $urandom_range(0, 3);
                if (sel != 1)
                    write_register(CFG_FRAME_WIDTH, {2'($urandom), WIDTH_BITS'(w_val)});
                if (sel != 0)
                    write_register(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h_val));
            end
            must_write = 1'b0;
            w = tracker.eff_width();
            h = tracker.eff_height();
            if ($urandom_range(0, 7) == 0) begin
                send_frame($urandom_range(0, w * h - 1), 0, 1'b1);
                must_write = 1'b1;
            end else begin
                send_frame(w * h, w + 1, 1'b1);
                // flush right after a frame end falls into the next frame: dropped
                if ($urandom_range(0, 5) == 0) send_request(random_sample(), 1'b1);
            end
        end
        wait_for_results();
    endtask

    initial begin
        int k;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_FRAME_WIDTH;
        i_cfg_data      = '0;
        counted_items   = 0;
        tracker         = new();

        send_idle_pct = 38;
        recv_idle_pct = 47;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 2x2 frame from clamped values; width data has bits above the field set
        write_register(CFG_FRAME_WIDTH, 13'h1001);
        write_register(CFG_FRAME_HEIGHT, 13'h0000);
        send_request(MOST_POSITIVE, 1'b1);
        send_request(MOST_NEGATIVE, 1'b0);
        send_request(MOST_POSITIVE, 1'b0);
        // writes to unused indexes mid-frame must not restart it
        wait_for_results();
        write_register(CFG_SPARE_A, 13'h1FFF);
        write_register(CFG_SPARE_B, 13'h0002);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        // drain: flush, a sample taken as drain, flush
        send_request(16'h1234, 1'b1);
        send_request(MOST_POSITIVE, 1'b0);
        send_request(16'h0001, 1'b1);
        send_request(16'h5555, 1'b1);

        // 3x3 frame of extremes and minus one for floor rounding
        wait_for_results();
        write_register(CFG_FRAME_WIDTH, 13'd3);
        write_register(CFG_FRAME_HEIGHT, 13'd3);
        for (k = 0; k < 9; k++)
            send_request((k % 3 == 2) ? 16'hFFFF : (k[0] ? MOST_POSITIVE : MOST_NEGATIVE),
                         1'b0);
        for (k = 0; k < 4; k++)
            send_request(16'h0000, 1'b1);

        run_random_frames(130);

        send_idle_pct = 47;
        recv_idle_pct = 38;
        run_random_frames(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // both registers above range, frame cut short by the next write
        write_register(CFG_FRAME_WIDTH, 13'h07FF);
        write_register(CFG_FRAME_HEIGHT, 13'h1FFF);
        send_frame(60, 0, 1'b1);
        run_random_frames(130);

        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_averages.size() != 0) @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/nas_pkg.sv
hw/rtl/nas_line_mem.sv
hw/rtl/nas_window_sum.sv
hw/rtl/nas_divider.sv
hw/rtl/nas_out_fifo.sv
hw/rtl/neighbor_average_smoother_unit.sv
hw/rtl/nas_checker.sv
sim/neighbor_average_smoother_unit_tb.sv
